// ===== rtl/tcaof_pkg.sv =====
`default_nettype none

package tcaof_pkg;

  localparam int unsigned REQ_W    = 2;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned PORT_TAG_W = 16;

  typedef enum logic [REQ_W-1:0] {
    REQ_ENQ     = 2'd0,
    REQ_DEQ_ANY = 2'd1,
    REQ_DEQ_C0  = 2'd2,
    REQ_DEQ_C1  = 2'd3
  } req_e;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_e;

  typedef struct packed {
    logic [REQ_W-1:0]      req_type;
    logic                  item_class;
    logic [PORT_TAG_W-1:0] item_tag;
  } in_item_t;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic                  out_class;
    logic [PORT_TAG_W-1:0] out_tag;
    logic                  all_empty;
  } out_item_t;

  typedef struct packed {
    logic empty;
    logic full;
    logic last;
  } q_flags_t;

endpackage

`default_nettype wire

// ===== rtl/tcaof_in_if.sv =====
`default_nettype none

interface tcaof_in_if;
  import tcaof_pkg::*;

  logic     valid;
  logic     ready;
  in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcaof_out_if.sv =====
`default_nettype none

interface tcaof_out_if;
  import tcaof_pkg::*;

  logic      valid;
  logic      ready;
  out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ===== rtl/tcaof_class_queue.sv =====
`default_nettype none

module tcaof_class_queue #(
  parameter int unsigned DEPTH      = 16,
  parameter int unsigned TAG_BITS   = 16,
  parameter int unsigned STAMP_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  logic                   pop_i,
  input  logic [TAG_BITS-1:0]    push_tag_i,
  input  logic [STAMP_BITS-1:0]  push_stamp_i,
  output tcaof_pkg::q_flags_t    flags_o,
  output logic [TAG_BITS-1:0]    head_tag_o,
  output logic [STAMP_BITS-1:0]  head_stamp_o
);
  import tcaof_pkg::*;

  localparam int unsigned PTR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned FILL_W  = $clog2(DEPTH + 1);
  localparam int unsigned ENTRY_W = TAG_BITS + STAMP_BITS;

  logic [ENTRY_W-1:0] mem_q [DEPTH];
  logic [ENTRY_W-1:0] rd_q;
  logic [ENTRY_W-1:0] wr_data;
  logic [PTR_W-1:0]   head_q, head_d, head_nxt;
  logic [PTR_W-1:0]   tail_q, tail_nxt;
  logic [FILL_W-1:0]  fill_q, fill_d;

  assign wr_data  = {push_tag_i, push_stamp_i};
  assign head_nxt = (head_q == PTR_W'(DEPTH - 1)) ? '0 : head_q + 1'b1;
  assign tail_nxt = (tail_q == PTR_W'(DEPTH - 1)) ? '0 : tail_q + 1'b1;
  assign head_d   = pop_i ? head_nxt : head_q;

  always_comb begin
    fill_d = fill_q;
    if (push_i) begin
      fill_d = fill_q + 1'b1;
    end else if (pop_i) begin
      fill_d = fill_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q <= '0;
      tail_q <= '0;
      fill_q <= '0;
    end else begin
      head_q <= head_d;
      fill_q <= fill_d;
      if (push_i) begin
        tail_q <= tail_nxt;
      end
    end
  end

  // The read register always holds the entry at the head; a write to that
  // slot is forwarded so the head is ready in the cycle after the write.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[tail_q] <= wr_data;
    end
    if (push_i && (tail_q == head_d)) begin
      rd_q <= wr_data;
    end else begin
      rd_q <= mem_q[head_d];
    end
  end

  assign head_tag_o    = rd_q[ENTRY_W-1:STAMP_BITS];
  assign head_stamp_o  = rd_q[STAMP_BITS-1:0];
  assign flags_o.empty = (fill_q == '0);
  assign flags_o.full  = (fill_q == FILL_W'(DEPTH));
  assign flags_o.last  = (fill_q == FILL_W'(1));

endmodule

`default_nettype wire

// ===== rtl/two_class_age_ordered_fifo_top.sv =====
// Channel  Direction  Transfer when        Payload
// in_i     sink       valid && ready       req_type, item_class, item_tag
// out_o    source     valid && ready       status, out_class, out_tag, all_empty
//
// Every request is decided in the cycle it is accepted and its result is
// shown from the output register in the next cycle; one request per cycle unless stalled.
// The head of each class queue sits in a registered read stage of its memory.
// A stalled result holds the output register, and a new request is still
// taken in the cycle that the waiting result is transferred.
// Reset clears pointers, fill counts and the arrival counter; no clearing pass.
`default_nettype none

module two_class_age_ordered_fifo_top #(
  parameter int unsigned QUEUE_DEPTH = 16,
  parameter int unsigned TAG_BITS    = 16,
  parameter int unsigned STAMP_BITS  = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  tcaof_in_if.sink           in_i,
  tcaof_out_if.source        out_o
);
  import tcaof_pkg::*;

  logic                  acc;
  logic                  push0, push1, pop0, pop1;
  logic                  pick_vld, pick_cls;
  status_e               status;
  q_flags_t              flags0, flags1;
  logic [TAG_BITS-1:0]   head_tag0, head_tag1, push_tag, pick_tag;
  logic [STAMP_BITS-1:0] head_stamp0, head_stamp1, age_diff;
  logic [STAMP_BITS-1:0] stamp_q, stamp_d;
  logic                  empty0_after, empty1_after;
  logic                  out_valid_q;
  out_item_t             out_data_q, result;

  assign acc      = in_i.valid && in_i.ready;
  assign in_i.ready = !out_valid_q || out_o.ready;
  assign push_tag = TAG_BITS'(in_i.data.item_tag);
  assign stamp_d  = stamp_q + 1'b1;
  assign age_diff = head_stamp1 - head_stamp0;

  always_comb begin
    status   = ST_OK;
    pick_vld = 1'b0;
    pick_cls = 1'b0;
    push0    = 1'b0;
    push1    = 1'b0;
    case (in_i.data.req_type)
      REQ_ENQ: begin
        if (in_i.data.item_class ? flags1.full : flags0.full) begin
          status = ST_FULL;
        end else begin
          push0 = !in_i.data.item_class;
          push1 = in_i.data.item_class;
        end
      end
      REQ_DEQ_C0: begin
        pick_vld = !flags0.empty;
        pick_cls = 1'b0;
      end
      REQ_DEQ_C1: begin
        pick_vld = !flags1.empty;
        pick_cls = 1'b1;
      end
      REQ_DEQ_ANY: begin
        pick_vld = !(flags0.empty && flags1.empty);
        if (flags0.empty) begin
          pick_cls = 1'b1;
        end else if (flags1.empty) begin
          pick_cls = 1'b0;
        end else begin
          pick_cls = age_diff[STAMP_BITS-1];
        end
      end
      default: begin
        status = ST_OK;
      end
    endcase
    if (in_i.data.req_type != REQ_ENQ && !pick_vld) begin
      status = ST_EMPTY;
    end
  end

  assign pop0     = acc && pick_vld && !pick_cls;
  assign pop1     = acc && pick_vld && pick_cls;
  assign pick_tag = pick_cls ? head_tag1 : head_tag0;

  assign empty0_after = (flags0.empty && !(acc && push0)) || (flags0.last && pop0);
  assign empty1_after = (flags1.empty && !(acc && push1)) || (flags1.last && pop1);

  always_comb begin
    result.status    = status;
    result.out_class = pick_vld && pick_cls;
    result.out_tag   = pick_vld ? PORT_TAG_W'(pick_tag) : '0;
    result.all_empty = empty0_after && empty1_after;
  end

  tcaof_class_queue #(
    .DEPTH      (QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_queue0 (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (acc && push0),
    .pop_i        (pop0),
    .push_tag_i   (push_tag),
    .push_stamp_i (stamp_d),
    .flags_o      (flags0),
    .head_tag_o   (head_tag0),
    .head_stamp_o (head_stamp0)
  );

  tcaof_class_queue #(
    .DEPTH      (QUEUE_DEPTH),
    .TAG_BITS   (TAG_BITS),
    .STAMP_BITS (STAMP_BITS)
  ) u_queue1 (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (acc && push1),
    .pop_i        (pop1),
    .push_tag_i   (push_tag),
    .push_stamp_i (stamp_d),
    .flags_o      (flags1),
    .head_tag_o   (head_tag1),
    .head_stamp_o (head_stamp1)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      stamp_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      if (acc && (push0 || push1)) begin
        stamp_q <= stamp_d;
      end
      if (acc) begin
        out_valid_q <= 1'b1;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (acc) begin
      out_data_q <= result;
    end
  end

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_data_q;

  a_no_pop_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((pop0 && flags0.empty) || (pop1 && flags1.empty)))
    else $error("Pop from an empty class queue.");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((acc && push0 && flags0.full) || (acc && push1 && flags1.full)))
    else $error("Push into a full class queue.");

  a_push_not_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (acc && (push0 || push1)) |=> (out_valid_q && !out_data_q.all_empty))
    else $error("Result after a stored item reports both queues empty.");

  a_stamp_advance: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !(acc && (push0 || push1)) |=> $stable(stamp_q))
    else $error("Arrival counter moved without a stored item.");

endmodule

`default_nettype wire
